// ===== rtl/core/ffaa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffaa_pkg
// Shared types and codes for the first-fit aligned allocator core.
// ----------------------------------------------------------------------------
package ffaa_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_BAD_OFF = 2'd3;

   // item modes
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [16:0] ALIGN_MAX    = 17'd65536;
   localparam logic [31:0] REGION_RESET = 32'd268435456;

   // one table entry
   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
      logic [15:0] pad;
      logic        used;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic init_table;
      logic load_item;
      logic rd_issue;
      logic mod_start;
      logic proc_entry;
      logic emit_rem;
      logic flush;
      logic send;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_mod;
      logic mod_done;
      logic split_now;
      logic last;
      logic rsp_busy;
   } dp_sts_type;

endpackage

// ===== rtl/core/ffaa_rem.sv =====
// ----------------------------------------------------------------------------
// ffaa_rem
// Bit-serial remainder unit: start % divisor, giving the pad that rounds
// start up to a multiple of divisor.
// ----------------------------------------------------------------------------
module ffaa_rem import ffaa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [15:0] pad
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [17:0] trial;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      trial   = {rem_ff, dvd_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = 17'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[16:0];
         end
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done = done_ff;
   // remainder is below divisor <= 65536, so the pad fits 16 bits
   assign pad  = (rem_ff == '0) ? 16'd0 : 16'(divisor - rem_ff);

endmodule

// ===== rtl/core/ffaa_dp.sv =====
// ----------------------------------------------------------------------------
// ffaa_dp
// Datapath: block table memory, item registers, first-fit / release match,
// streaming rewrite with split insert and free-block merging, free totals.
// ----------------------------------------------------------------------------
module ffaa_dp import ffaa_pkg::*; #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_sts_type   sts,
   input  logic         req_mode,
   input  logic [31:0]  req_request_size,
   input  logic [16:0]  req_alignment,
   input  logic [31:0]  req_release_offset,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output logic [1:0]   rsp_status,
   output logic [31:0]  rsp_offset,
   output logic [31:0]  rsp_total_free,
   output logic [31:0]  rsp_largest_free
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   // table memory
   entry_type tbl_mem [MAX_BLOCKS];
   entry_type rd_q_ff;
   logic      mem_we;
   logic [IW-1:0] mem_addr;
   entry_type mem_wdata;

   logic [31:0] region_ff;
   logic        mode_ff;
   logic [31:0] size_ff;
   logic [16:0] align_ff;
   logic [31:0] rel_ff;
   logic [CW-1:0] rd_idx_ff, wr_idx_ff, count_ff;
   entry_type held_ff, rem_ent_ff;
   logic        held_vld_ff;
   logic        found_ff, full_ff, pad_ok_ff;
   logic [31:0] off_ff;
   logic [15:0] pad_ff;
   logic [31:0] tot_ff, lrg_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_offset_ff, rsp_total_ff, rsp_largest_ff;

   logic        mod_done;
   logic [15:0] mod_pad;

   entry_type   cur, proc_ent, em_ent;
   logic        candidate, take, split, tbl_full, full_hit, split_now, match;
   logic [32:0] need;
   logic        emit, merge, wb;

   ffaa_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mod_start),
      .dividend (rd_q_ff.start),
      .divisor  (align_ff),
      .done     (mod_done),
      .pad      (mod_pad)
   );

   // entry evaluation
   always_comb begin
      cur       = rd_q_ff;
      candidate = (mode_ff == MODE_ALLOC) && !found_ff && !cur.used &&
                  (cur.length >= size_ff);
      need      = {1'b0, size_ff} + {17'd0, pad_ff};
      take      = candidate && pad_ok_ff && ({1'b0, cur.length} >= need);
      split     = take && ({1'b0, cur.length} != need);
      tbl_full  = (count_ff == CW'(MAX_BLOCKS));
      full_hit  = split && tbl_full;
      split_now = split && !tbl_full;
      match     = (mode_ff == MODE_FREE) && !found_ff && cur.used &&
                  ((cur.start + {16'd0, cur.pad}) == rel_ff);
      proc_ent  = cur;
      if (take && !full_hit) begin
         proc_ent.length = need[31:0];
         proc_ent.pad    = pad_ff;
         proc_ent.used   = 1'b1;
      end else if (match) begin
         proc_ent.pad  = '0;
         proc_ent.used = 1'b0;
      end
      emit   = cmd.proc_entry || cmd.emit_rem;
      em_ent = cmd.emit_rem ? rem_ent_ff : proc_ent;
      merge  = held_vld_ff && !held_ff.used && !em_ent.used;
      wb     = (emit && held_vld_ff && !merge) || cmd.flush;
   end

   // memory write port select
   always_comb begin
      mem_we    = cmd.init_table || wb;
      mem_addr  = cmd.init_table ? '0 : wr_idx_ff[IW-1:0];
      mem_wdata = held_ff;
      if (cmd.init_table) begin
         mem_wdata = '{start: 32'd0, length: region_ff, pad: 16'd0, used: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_addr] <= mem_wdata;
      end
      if (cmd.rd_issue) begin
         rd_q_ff <= tbl_mem[rd_idx_ff[IW-1:0]];
      end
   end

   // control and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= REGION_RESET;
         count_ff     <= CW'(1);
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         held_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         full_ff      <= 1'b0;
         pad_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            region_ff <= csr_wdata;
         end
         if (cmd.init_table) begin
            count_ff <= CW'(1);
         end
         // item capture, with clamping of size and alignment
         if (cmd.load_item) begin
            mode_ff     <= req_mode;
            size_ff     <= (req_request_size == '0) ? 32'd1 : req_request_size;
            if (req_alignment == '0) begin
               align_ff <= 17'd1;
            end else if (req_alignment > ALIGN_MAX) begin
               align_ff <= ALIGN_MAX;
            end else begin
               align_ff <= req_alignment;
            end
            rel_ff      <= req_release_offset;
            rd_idx_ff   <= '0;
            wr_idx_ff   <= '0;
            held_vld_ff <= 1'b0;
            found_ff    <= 1'b0;
            full_ff     <= 1'b0;
            pad_ok_ff   <= 1'b0;
            off_ff      <= '0;
            tot_ff      <= '0;
            lrg_ff      <= '0;
         end
         if (cmd.rd_issue) begin
            pad_ok_ff <= 1'b0;
         end
         if (mod_done) begin
            pad_ff    <= mod_pad;
            pad_ok_ff <= 1'b1;
         end
         // decision on the current entry
         if (cmd.proc_entry) begin
            if (take) begin
               found_ff <= 1'b1;
               if (full_hit) begin
                  full_ff <= 1'b1;
               end else begin
                  off_ff <= cur.start + {16'd0, pad_ff};
               end
               if (split_now) begin
                  rem_ent_ff <= '{start: cur.start + {16'd0, pad_ff} + size_ff,
                                  length: 32'(cur.length - need[31:0]),
                                  pad: 16'd0, used: 1'b0};
               end
            end else if (match) begin
               found_ff <= 1'b1;
            end
            if (!split_now) begin
               rd_idx_ff <= rd_idx_ff + CW'(1);
            end
         end
         if (cmd.emit_rem) begin
            rd_idx_ff <= rd_idx_ff + CW'(1);
         end
         // merge stage
         if (emit) begin
            held_vld_ff <= 1'b1;
            if (merge) begin
               held_ff <= '{start: held_ff.start,
                            length: held_ff.length + em_ent.length,
                            pad: 16'd0, used: 1'b0};
            end else begin
               held_ff <= em_ent;
            end
         end
         // written-back entries feed the free totals
         if (wb) begin
            wr_idx_ff <= wr_idx_ff + CW'(1);
            if (!held_ff.used) begin
               tot_ff <= tot_ff + held_ff.length;
               if (held_ff.length > lrg_ff) begin
                  lrg_ff <= held_ff.length;
               end
            end
         end
         if (cmd.flush) begin
            count_ff <= wr_idx_ff + CW'(1);
         end
         // result register
         if (cmd.send) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.send) begin
         rsp_total_ff   <= tot_ff;
         rsp_largest_ff <= lrg_ff;
         rsp_offset_ff  <= '0;
         if (mode_ff == MODE_FREE) begin
            rsp_status_ff <= found_ff ? STATUS_OK : STATUS_BAD_OFF;
         end else if (!found_ff) begin
            rsp_status_ff <= STATUS_NO_FIT;
         end else if (full_ff) begin
            rsp_status_ff <= STATUS_FULL;
         end else begin
            rsp_status_ff <= STATUS_OK;
            rsp_offset_ff <= off_ff;
         end
      end
   end

   always_comb begin
      sts.need_mod  = candidate && !pad_ok_ff;
      sts.mod_done  = mod_done;
      sts.split_now = split_now;
      sts.last      = (rd_idx_ff == count_ff - CW'(1));
      sts.rsp_busy  = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_offset       = rsp_offset_ff;
   assign rsp_total_free   = rsp_total_ff;
   assign rsp_largest_free = rsp_largest_ff;

endmodule

// ===== rtl/core/ffaa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffaa_ctrl
// Sequencer: table init, per-entry read / evaluate / remainder insert,
// final write-back and result hand-off.
// ----------------------------------------------------------------------------
module ffaa_ctrl import ffaa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         csr_we,
   input  dp_sts_type   sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_READ, ST_PROC, ST_MOD, ST_EXTRA, ST_FLUSH, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_table = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_we) begin
               state_in = ST_INIT;
            end else if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_PROC;
         end
         ST_PROC: begin
            if (sts.need_mod) begin
               cmd.mod_start = 1'b1;
               state_in      = ST_MOD;
            end else begin
               cmd.proc_entry = 1'b1;
               if (sts.split_now) begin
                  state_in = ST_EXTRA;
               end else if (sts.last) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               state_in = ST_PROC;
            end
         end
         ST_EXTRA: begin
            cmd.emit_rem = 1'b1;
            state_in     = sts.last ? ST_FLUSH : ST_READ;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.send = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || csr_we;

endmodule

// ===== rtl/core/first_fit_aligned_allocator_core.sv =====
// Each table entry walked is read and then evaluated; each free block at least
// as long as the request, up to the first fit, first runs the serial remainder
// for the alignment pad. A split inserts the remainder entry as an extra step,
// then the table is flushed and the result issued. One item at a time: the next
// item is taken only after the result is issued, so the table walk sets the
// rate; a stalled result waits. Reset and region writes made while idle rebuild the table; items are held off.
// ----------------------------------------------------------------------------
// first_fit_aligned_allocator_core
// First-fit aligned region allocator with split and free-block merging.
// ----------------------------------------------------------------------------
module first_fit_aligned_allocator_core import ffaa_pkg::*; #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_request_size,
   input  logic [16:0] req_alignment,
   input  logic [31:0] req_release_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_offset,
   output logic [31:0] rsp_total_free,
   output logic [31:0] rsp_largest_free,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   ffaa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_we    (csr_we),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffaa_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_mode),
      .req_request_size   (req_request_size),
      .req_alignment      (req_alignment),
      .req_release_offset (req_release_offset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_offset         (rsp_offset),
      .rsp_total_free     (rsp_total_free),
      .rsp_largest_free   (rsp_largest_free)
   );

endmodule
